>>> rtl/btnclass_pkg.sv
package btnclass_pkg;

    // taps that complete one multi-tap gesture
    localparam int unsigned TAPS_FOR_GESTURE = 3;
    localparam int unsigned TAP_W = $clog2(TAPS_FOR_GESTURE);

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // register reset values
    localparam logic [CFG_W-1:0] HOLD_THRESHOLD_RST = 16'd3000;
    localparam logic [CFG_W-1:0] TAP_TIMEOUT_RST = 16'd1500;
    localparam logic HOLD_ENABLE_RST = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_THRESHOLD = 2'd0,
        CFG_TAP_TIMEOUT = 2'd1,
        CFG_HOLD_ENABLE = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        EVT_NONE = 3'd0,
        EVT_TAP = 3'd1,
        EVT_LONG = 3'd2,
        EVT_TRIPLE = 3'd3,
        EVT_TIMEOUT = 3'd4
    } gesture_t;

    typedef logic [TAP_W-1:0] tap_cnt_t;

    // held count as shown on the output, saturating at 3
    function automatic logic [1:0] shown_taps(tap_cnt_t cnt);
        logic [3:0] wide;
        wide = 4'(cnt);
        if (wide > 4'd3) begin
            return 2'd3;
        end
        return wide[1:0];
    endfunction

endpackage

>>> rtl/button_tap_hold_classifier.sv
// Button tap / long-press classifier. Each sample transaction carries the
// button level and a free-running millisecond timestamp; every sample gives
// exactly one event transaction (none, tap, long press, triple tap or tap
// timeout) together with the tap count still pending. A release that was held
// at least the hold threshold reports a long press when hold_enable is set,
// otherwise it counts a tap; the third tap reports a triple tap, and a pending
// count with no new tap for more than tap_timeout_ms clears with a timeout.
// All time differences wrap modulo 2^32. Throughput is one sample per clock
// while events are not stalled; a sample goes from the input register
// through the classify logic into the result register, which holds its event
// and updates the gesture state. Registers go through the always-ready cfg
// port; the user must write them with no sample in flight (not enforced).
module button_tap_hold_classifier (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // sample channel
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  logic                                   button_pressed,
    input  logic [btnclass_pkg::TIME_W-1:0]        now_ms,
    // event channel
    output logic                                   event_valid,
    input  logic                                   event_stall,
    output logic [2:0]                             gesture_event,
    output logic [1:0]                             pending_taps,
    // register write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [btnclass_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [btnclass_pkg::CFG_W-1:0]         cfg_data
);

    // configuration registers
    logic [btnclass_pkg::CFG_W-1:0] hold_threshold_reg;
    logic [btnclass_pkg::CFG_W-1:0] tap_timeout_reg;
    logic                           hold_enable_reg;

    // input stage
    logic                            in_valid_reg;
    logic                            in_level_reg;
    logic [btnclass_pkg::TIME_W-1:0] in_now_reg;

    // gesture state
    logic                            was_pressed_reg;
    logic                            was_pressed_next;
    logic [btnclass_pkg::TIME_W-1:0] press_start_reg;
    logic [btnclass_pkg::TIME_W-1:0] press_start_next;
    btnclass_pkg::tap_cnt_t          tap_count_reg;
    btnclass_pkg::tap_cnt_t          tap_count_next;
    logic [btnclass_pkg::TIME_W-1:0] last_tap_reg;
    logic [btnclass_pkg::TIME_W-1:0] last_tap_next;

    // result stage
    logic                            out_valid_reg;
    btnclass_pkg::gesture_t          evt_reg;
    btnclass_pkg::gesture_t          evt_next;
    logic [1:0]                      shown_reg;
    logic [1:0]                      shown_next;

    // pipeline control
    logic out_free;
    logic in_move;
    logic sample_take;

    // datapath
    logic [btnclass_pkg::TIME_W-1:0] held_ms;
    logic [btnclass_pkg::TIME_W-1:0] idle_ms;
    logic [btnclass_pkg::TAP_W:0]    tap_inc;
    logic                            press_edge;
    logic                            release_edge;

    // result register frees up when empty or its transaction completes
    assign out_free = !out_valid_reg || !event_stall;
    assign in_move = in_valid_reg && out_free;
    // input register takes a sample whenever it is empty or draining
    assign sample_stall = in_valid_reg && !out_free;
    assign sample_take = sample_valid && !sample_stall;

    assign event_valid = out_valid_reg;
    assign gesture_event = evt_reg;
    assign pending_taps = shown_reg;
    assign cfg_ready = 1'b1;

    // register writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_threshold_reg <= btnclass_pkg::HOLD_THRESHOLD_RST;
            tap_timeout_reg <= btnclass_pkg::TAP_TIMEOUT_RST;
            hold_enable_reg <= btnclass_pkg::HOLD_ENABLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                btnclass_pkg::CFG_HOLD_THRESHOLD: hold_threshold_reg <= cfg_data;
                btnclass_pkg::CFG_TAP_TIMEOUT: tap_timeout_reg <= cfg_data;
                btnclass_pkg::CFG_HOLD_ENABLE: hold_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (in_move)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            in_level_reg <= button_pressed;
            in_now_reg <= now_ms;
        end
    end

    assign press_edge = in_level_reg && !was_pressed_reg;
    assign release_edge = !in_level_reg && was_pressed_reg;
    // both differences wrap modulo 2^32
    assign held_ms = in_now_reg - press_start_reg;
    assign idle_ms = in_now_reg - last_tap_reg;
    assign tap_inc = {1'b0, tap_count_reg} + 1'b1;

    // classify one sample
    always_comb
    begin
        was_pressed_next = in_level_reg;
        press_start_next = press_start_reg;
        tap_count_next = tap_count_reg;
        last_tap_next = last_tap_reg;
        evt_next = btnclass_pkg::EVT_NONE;

        if (press_edge)
        begin
            press_start_next = in_now_reg;
        end

        if (release_edge)
        begin
            if (hold_enable_reg && held_ms >= 32'(hold_threshold_reg))
            begin
                // long press cancels any tap sequence
                evt_next = btnclass_pkg::EVT_LONG;
                tap_count_next = '0;
                last_tap_next = '0;
            end
            else
            begin
                last_tap_next = in_now_reg;
                if (tap_inc >= (btnclass_pkg::TAP_W + 1)'(btnclass_pkg::TAPS_FOR_GESTURE))
                begin
                    evt_next = btnclass_pkg::EVT_TRIPLE;
                    tap_count_next = '0;
                end
                else
                begin
                    evt_next = btnclass_pkg::EVT_TAP;
                    tap_count_next = tap_inc[btnclass_pkg::TAP_W-1:0];
                end
            end
        end
        else if (tap_count_reg != '0 && idle_ms > 32'(tap_timeout_reg))
        begin
            // a tap on this sample leaves zero idle time, so only a
            // sample without a release can time out
            evt_next = btnclass_pkg::EVT_TIMEOUT;
            tap_count_next = '0;
        end

        shown_next = btnclass_pkg::shown_taps(tap_count_next);
    end

    // gesture state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            was_pressed_reg <= 1'b0;
            press_start_reg <= '0;
            tap_count_reg <= '0;
            last_tap_reg <= '0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                was_pressed_reg <= was_pressed_next;
                press_start_reg <= press_start_next;
                tap_count_reg <= tap_count_next;
                last_tap_reg <= last_tap_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_move)
        begin
            evt_reg <= evt_next;
            shown_reg <= shown_next;
        end
    end

endmodule
